// File: rtl/atnpc_pkg.sv
// Package for the ARM/Thumb next-address unit: field widths, kind codes and helpers.
// Depends on nothing; the register file, decoder and top level import it.
`default_nettype none
package atnpc_pkg;
    typedef enum logic [1:0] {
        KIND_DIRECT = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_TBB    = 2'd2,
        KIND_TBH    = 2'd3
    } t_kind;

    localparam logic       OP_WRITE   = 1'b0;
    localparam logic       OP_COMPUTE = 1'b1;
    localparam logic [4:0] IDX_STATUS = 5'd16;
    localparam logic [3:0] COND_AL    = 4'd14;
    localparam logic [3:0] COND_NV    = 4'd15;

    typedef struct packed {
        logic [31:0] cur_pc;
        logic [31:0] instr_word;
    } t_req;

    typedef struct packed {
        logic [31:0] first_target;
        t_kind       first_kind;
        logic        second_valid;
        logic [31:0] second_target;
    } t_res;

    // Population count of a 16-bit register list.
    function automatic logic [4:0] f_pop16(input logic [15:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 16; i++) n = n + {4'd0, v[i]};
        return n;
    endfunction
endpackage
`default_nettype wire

// File: rtl/atnpc_if.sv
// Valid/ready channel interfaces for the next-address unit.
// Depends on nothing.
`default_nettype none
interface atnpc_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] cur_pc;
    logic [31:0] instr_word;
    modport source (output valid, operation, reg_index, reg_value, cur_pc, instr_word,
                    input ready);
    modport sink (input valid, operation, reg_index, reg_value, cur_pc, instr_word,
                  output ready);
endinterface

interface atnpc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] first_target;
    logic [1:0]  first_kind;
    logic        second_valid;
    logic [31:0] second_target;
    modport source (output valid, first_target, first_kind, second_valid, second_target,
                    input ready);
    modport sink (input valid, first_target, first_kind, second_valid, second_target,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/atnpc_regs.sv
// Register file of the next-address unit: sixteen general registers and the status word.
// Depends on atnpc_pkg.
`default_nettype none
module atnpc_regs
    import atnpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_we,
    input  wire logic [4:0]  i_idx,
    input  wire logic [31:0] i_val,
    output logic [15:0][31:0] o_gp,
    output logic [31:0]      o_status
);
    logic [15:0][31:0] r_gp;
    logic [31:0]       r_status;

    // Writes to indexes beyond the status word are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp     <= '0;
            r_status <= '0;
        end else if (i_we) begin
            if (!i_idx[4]) begin
                r_gp[i_idx[3:0]] <= i_val;
            end else if (i_idx == IDX_STATUS) begin
                r_status <= i_val;
            end
        end
    end

    assign o_gp     = r_gp;
    assign o_status = r_status;
endmodule
`default_nettype wire

// File: rtl/atnpc_decode.sv
// Combinational decoder: A32 and Thumb next-address computation.
// Depends on atnpc_pkg.
`default_nettype none
module atnpc_decode
    import atnpc_pkg::*;
(
    input  wire t_req         i_req,
    input  wire logic [15:0][31:0] i_gp,
    input  wire logic [31:0]  i_status,
    output t_res              o_res
);
    logic [31:0] pc, w;
    logic [15:0] i1, i2;
    logic        c;

    always_comb begin
        pc = i_req.cur_pc;
        w  = i_req.instr_word;
        i1 = w[15:0];
        i2 = w[31:16];
        c  = i_status[29];
    end

    // A32 register reads with pc+8 for r15.
    function automatic logic [31:0] f_ra(input logic [3:0] i, input logic [31:0] p,
                                         input logic [15:0][31:0] g);
        return (i == 4'd15) ? p + 32'd8 : g[i];
    endfunction

    function automatic logic [31:0] f_rd(input logic [3:0] i, input logic [31:0] p,
                                         input logic [15:0][31:0] g);
        return (i == 4'd15) ? p : g[i];
    endfunction

    // A32 shifter operand.
    logic [31:0] sh_v, sh_out, rs_val;
    logic [7:0]  sh_amt;
    logic [4:0]  sh_r;
    always_comb begin
        rs_val = f_ra(w[11:8], pc, i_gp);
        sh_amt = w[4] ? rs_val[7:0] : {3'd0, w[11:7]};
        sh_v   = (w[3:0] == 4'd15) ? pc + (w[4] ? 32'd12 : 32'd8) : i_gp[w[3:0]];
        sh_r   = sh_amt[4:0];
        unique case (w[6:5])
            2'd0: sh_out = (sh_amt >= 8'd32) ? 32'd0 : sh_v << sh_amt[4:0];
            2'd1: sh_out = (sh_amt >= 8'd32) ? 32'd0 : sh_v >> sh_amt[4:0];
            2'd2: sh_out = $unsigned($signed(sh_v) >>>
                           ((sh_amt >= 8'd32) ? 5'd31 : sh_amt[4:0]));
            default: sh_out = (sh_r == 5'd0) ? {c, sh_v[31:1]}
                              : ((sh_v >> sh_r) | (sh_v << (6'd32 - {1'b0, sh_r})));
        endcase
    end

    // A32 decode.
    logic        a_have;
    logic [31:0] a_t, op1, op2, imm_rot, ls_base, ls_off, ldm_off;
    t_kind       a_k;
    logic [4:0]  rot;
    always_comb begin
        a_have  = 1'b0;
        a_t     = '0;
        a_k     = KIND_DIRECT;
        op1     = f_ra(w[19:16], pc, i_gp);
        rot     = {w[11:8], 1'b0};
        imm_rot = ({24'd0, w[7:0]} >> rot) | ({24'd0, w[7:0]} << (6'd32 - {1'b0, rot}));
        if (rot == 5'd0) imm_rot = {24'd0, w[7:0]};
        op2     = w[25] ? imm_rot : sh_out;
        ls_off  = w[25] ? sh_out : {20'd0, w[11:0]};
        ls_base = w[24] ? (w[23] ? op1 + ls_off : op1 - ls_off) : op1;
        ldm_off = '0;
        if (w[23]) begin
            ldm_off = {25'd0, f_pop16({1'b0, w[14:0]}), 2'd0} + (w[24] ? 32'd4 : 32'd0);
        end else if (w[24]) begin
            ldm_off = 32'hffff_fffc;
        end
        if (w[31:28] == COND_NV) begin
            if (w[27:25] == 3'b101) begin
                a_have = 1'b1;
                a_t = (pc + {{6{w[23]}}, w[23:0], 2'd0} + 32'd8) | {30'd0, w[24], 1'b1};
            end
        end else begin
            unique case (w[27:26])
                2'd0: begin
                    if (w[15:12] == 4'd15 &&
                        !(w[25:22] == 4'd0 && w[7:4] == 4'd9)) begin
                        a_have = 1'b1;
                        if (w[27:4] == 24'h12fff1 || w[27:4] == 24'h12fff3) begin
                            a_t = f_ra(w[3:0], pc, i_gp);
                        end else begin
                            unique case (w[24:21])
                                4'd0:  a_t = op1 & op2;
                                4'd1:  a_t = op1 ^ op2;
                                4'd2:  a_t = op1 - op2;
                                4'd3:  a_t = op2 - op1;
                                4'd4:  a_t = op1 + op2;
                                4'd5:  a_t = op1 + op2 + {31'd0, c};
                                4'd6:  a_t = op1 - op2 - {31'd0, !c};
                                4'd7:  a_t = op2 - op1 - {31'd0, !c};
                                4'd12: a_t = op1 | op2;
                                4'd13: a_t = op2;
                                4'd14: a_t = op1 & ~op2;
                                4'd15: a_t = ~op2;
                                default: a_t = '0;
                            endcase
                        end
                    end
                end
                2'd1: begin
                    if (w[20] && w[15:12] == 4'd15 && !w[22]) begin
                        a_have = 1'b1;
                        a_t = ls_base;
                        a_k = KIND_WORD;
                    end
                end
                2'd2: begin
                    if (!w[25]) begin
                        if (w[20] && w[15]) begin
                            a_have = 1'b1;
                            a_t = f_rd(w[19:16], pc, i_gp) + ldm_off;
                            a_k = KIND_WORD;
                        end
                    end else begin
                        a_have = 1'b1;
                        a_t = pc + {{6{w[23]}}, w[23:0], 2'd0} + 32'd8;
                    end
                end
                default: ;
            endcase
        end
    end

    // Thumb decode.
    logic        t_have, t_fall, wide;
    logic [31:0] t_t, off_bl, off_bc, tb, tl, tm_off, tbase, rn15, rm_t;
    t_kind       t_k;
    always_comb begin
        t_have = 1'b0;
        t_fall = 1'b0;
        t_t    = '0;
        t_k    = KIND_DIRECT;
        wide   = (i1[15:13] == 3'b111) && (i1[12:11] != 2'b00);
        off_bl = {{9{i1[10]}}, i1[10:0], 12'd0} + {20'd0, i2[10:0], 1'b0};
        if (!i2[11]) off_bl = off_bl ^ 32'h0040_0000;
        if (!i2[13]) off_bl = off_bl ^ 32'h0080_0000;
        off_bc = (i1[10] ? 32'hfff0_0000 : 32'd0) + {12'd0, i2[11], i2[13], i1[5:0],
                 i2[10:0], 1'b0};
        tm_off = '0;
        if (i1[7] && !i1[8]) tm_off = {25'd0, f_pop16(i2), 2'd0} - 32'd4;
        else if (!i1[7] && i1[8]) tm_off = 32'hffff_fffc;
        else if (!i1[7] && !i1[8]) tm_off = 32'hffff_fff8;
        tbase = f_rd(i1[3:0], pc, i_gp);
        rm_t  = f_rd(i2[3:0], pc, i_gp);
        rn15  = (pc + 32'd4) & 32'hffff_fffc;
        tl    = '0;
        if (i1[3:0] == 4'd15) tl = i1[7] ? rn15 + {20'd0, i2[11:0]}
                                         : rn15 - {20'd0, i2[11:0]};
        else if (i1[7]) tl = tbase + {20'd0, i2[11:0]};
        else if (i2[11]) tl = !i2[10] ? tbase : (i2[9] ? tbase + {24'd0, i2[7:0]}
                                                       : tbase - {24'd0, i2[7:0]});
        else tl = tbase + (rm_t << i2[5:4]);
        tb = (i1[3:0] == 4'd15) ? pc + 32'd4 : i_gp[i1[3:0]];
        if (i1[15:8] == 8'hbd) begin
            t_have = 1'b1;
            t_t = i_gp[13] + {25'd0, f_pop16({8'd0, i1[7:0]}), 2'd0};
            t_k = KIND_WORD;
        end else if (i1[15:12] == 4'hd) begin
            if (i1[11:8] != COND_NV) begin
                t_have = 1'b1;
                t_t = pc + 32'd4 + {{23{i1[7]}}, i1[7:0], 1'b0};
                t_fall = i1[11:8] != COND_AL;
            end
        end else if (i1[15:11] == 5'b11100) begin
            t_have = 1'b1;
            t_t = pc + 32'd4 + {{20{i1[10]}}, i1[10:0], 1'b0};
        end else if (wide) begin
            if (i1[15:11] == 5'b11110 && i2[15]) begin
                if (i2[12] || (i2[15:12] & 4'hd) == 4'hc && !i2[0]) begin
                    t_have = 1'b1;
                    t_t = pc + 32'd4 + off_bl;
                    if (!i2[12]) t_t[1:0] = 2'd0;
                end else if (i1 == 16'hf3de && i2[15:8] == 8'h3f) begin
                    t_have = 1'b1;
                    t_t = i_gp[14] - {24'd0, i2[7:0]};
                end else if ((i2[15:12] & 4'hd) == 4'h8 && i1[9:7] != 3'b111) begin
                    t_have = 1'b1;
                    t_t = pc + 32'd4 + off_bc;
                    t_fall = i1[9:6] != COND_AL;
                end
            end else if ((i1 & 16'hfe50) == 16'he810) begin
                if (!(i1[7] ^ i1[8]) || i2[15]) begin
                    t_have = 1'b1;
                    t_t = tbase + tm_off;
                    t_k = KIND_WORD;
                end
            end else if ((i1 & 16'hffef) == 16'hea4f && i2[15:4] == 12'h0f0) begin
                t_have = 1'b1;
                t_t = f_rd(i2[3:0], pc, i_gp);
            end else if ((i1 & 16'hff70) == 16'hf850 && i2[15:12] == 4'hf) begin
                if (i1[3:0] == 4'd15 || i1[7] || i2[11] || i2[11:6] == 6'd0) begin
                    t_have = 1'b1;
                    t_t = tl;
                    t_k = KIND_WORD;
                end
            end else if (i1[15:4] == 12'he8d && i2[15:5] == 11'h780) begin
                t_have = 1'b1;
                if (i2[4]) begin
                    t_t = tb + {rm_t[30:0], 1'b0};
                    t_k = KIND_TBH;
                end else begin
                    t_t = tb + rm_t;
                    t_k = KIND_TBB;
                end
            end
        end
    end

    // Result selection.
    logic [31:0] tsize;
    always_comb begin
        tsize = pc + (wide ? 32'd4 : 32'd2);
        o_res = '0;
        if (i_status[5]) begin
            if (t_have) begin
                o_res.first_target = t_t;
                o_res.first_kind   = t_k;
                o_res.second_valid = t_fall;
                o_res.second_target = t_fall ? tsize : 32'd0;
            end else begin
                o_res.first_target = tsize;
            end
        end else if (a_have) begin
            o_res.first_target = a_t;
            o_res.first_kind   = a_k;
            o_res.second_valid = w[31:28] != COND_AL;
            o_res.second_target = (w[31:28] != COND_AL) ? pc + 32'd4 : 32'd0;
        end else begin
            o_res.first_target = pc + 32'd4;
        end
    end
endmodule
`default_nettype wire

// File: rtl/arm_thumb_next_pc_calc.sv
// Top level of the ARM/Thumb next-address unit: input register, decoder, result register.
// Depends on atnpc_pkg, atnpc_if, atnpc_regs and atnpc_decode.
//
// Takes one transaction per cycle while the skid entry is free. A register write updates
// the register file at its acceptance edge and gives no result. A compute transaction is
// captured in an input register, decoded by one pass of combinational logic against the
// register file and lands in the result register, or in its skid entry while the result
// register is held. The result register has a one-entry skid stage, so input is taken
// while a result waits; once the skid entry is full, input ready drops and a compute
// transaction already in the input register holds there until the result side drains.
// Without output stalls throughput is one transaction per cycle.
`default_nettype none
module arm_thumb_next_pc_calc
    import atnpc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    atnpc_in_if.sink   i_in,
    atnpc_out_if.source o_out
);
    logic        r_v1, r_ov, r_sv;
    t_req        r_req;
    t_res        r_out, r_skid, res;
    logic [15:0][31:0] gp;
    logic [31:0] status;
    logic        acc;
    logic        take, v1_move;

    // Accept while the skid entry is free.
    assign i_in.ready = !r_sv;
    assign acc = i_in.valid && i_in.ready;

    atnpc_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_we(acc && i_in.operation == OP_WRITE),
        .i_idx(i_in.reg_index), .i_val(i_in.reg_value),
        .o_gp(gp), .o_status(status)
    );

    atnpc_decode u_dec (.i_req(r_req), .i_gp(gp), .i_status(status), .o_res(res));

    // The input stage can move on unless the result is full and stalled and the skid entry is full.
    assign take    = o_out.ready || !r_ov;
    assign v1_move = take || !r_sv;

    // Input register; a transaction that cannot move on is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else r_v1 <= (acc && i_in.operation == OP_COMPUTE) || (r_v1 && !v1_move);
        if (acc) begin
            r_req.cur_pc     <= i_in.cur_pc;
            r_req.instr_word <= i_in.instr_word;
        end
    end

    // Result register with a skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (take) begin
            if (r_sv) begin
                r_out <= r_skid;
                r_ov  <= 1'b1;
                r_sv  <= r_v1;
                r_skid <= res;
            end else begin
                r_out <= res;
                r_ov  <= r_v1;
            end
        end else if (r_v1 && !r_sv) begin
            r_skid <= res;
            r_sv   <= 1'b1;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.first_target  = r_out.first_target;
    assign o_out.first_kind    = r_out.first_kind;
    assign o_out.second_valid  = r_out.second_valid;
    assign o_out.second_target = r_out.second_target;
endmodule
`default_nettype wire
